### design/isqrt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isqrt_pkg
// Shared constant for the pipelined integer square root.
// ----------------------------------------------------------------------------
package isqrt_pkg;

  // Root bits resolved by each pipeline stage (one compare/subtract each)
  localparam int unsigned STEPS_PER_STAGE = 2;

endpackage

### design/isqrt_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isqrt_stage
// One register stage of the restoring square root: resolves STEPS_PER_STAGE
// root bits from the next operand bit pairs, with local valid/ready control.
// ----------------------------------------------------------------------------
module isqrt_stage import isqrt_pkg::*; #(
  parameter int unsigned ROOT_BITS = 16,
  parameter int unsigned PAD_BITS  = 32,
  localparam int unsigned REM_BITS = ROOT_BITS + 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  logic [REM_BITS-1:0]  rem_i,
  input  logic [ROOT_BITS-1:0] root_i,
  input  logic [PAD_BITS-1:0]  opnd_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output logic [REM_BITS-1:0]  rem_o,
  output logic [ROOT_BITS-1:0] root_o,
  output logic [PAD_BITS-1:0]  opnd_o
);

  localparam int unsigned SHIFT_BITS = 2 * STEPS_PER_STAGE;

  logic                 valid_q;
  logic [REM_BITS-1:0]  rem_d, rem_q;
  logic [ROOT_BITS-1:0] root_d, root_q;
  logic [PAD_BITS-1:0]  opnd_d, opnd_q;

  always_comb begin
    logic [REM_BITS-1:0]  rem;
    logic [REM_BITS-1:0]  trial;
    logic [ROOT_BITS-1:0] root;
    rem  = rem_i;
    root = root_i;
    for (int unsigned s = 0; s < STEPS_PER_STAGE; s++) begin
      // remainder stays below 2*root+1, so the top two bits never carry data
      rem   = {rem[REM_BITS-3:0], opnd_i[PAD_BITS-1-2*s -: 2]};
      trial = {root, 2'b01};
      if (rem >= trial) begin
        rem  = rem - trial;
        root = {root[ROOT_BITS-2:0], 1'b1};
      end else begin
        root = {root[ROOT_BITS-2:0], 1'b0};
      end
    end
    rem_d  = rem;
    root_d = root;
    opnd_d = {opnd_i[PAD_BITS-1-SHIFT_BITS:0], {SHIFT_BITS{1'b0}}};
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      rem_q  <= rem_d;
      root_q <= root_d;
      opnd_q <= opnd_d;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;
  assign opnd_o  = opnd_q;

endmodule

### design/integer_square_root_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_square_root_top
// Pipelined floor square root of an unsigned operand.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: radicand_i with valid_i; the block drives stall_o.
//   Output channel: root_o with valid_o; the receiver drives stall_i.
//   A request moves at a clock edge where valid is high and stall is low.
//   root_o is floor(sqrt(radicand_i)), (OPERAND_BITS+1)/2 bits wide.
// Pipeline: each register stage resolves two root bits with two chained
//   compare/subtracts, which sets the stage depth.
// Throughput: one request per cycle while the output is not stalled.
// Stall: each stage holds its request until the next stage has room, so
//   empty stages still fill while the output is stalled; stall_o rises only
//   once every stage is full.
// Reset: all stage valid bits clear; no request is in flight afterwards.
// ----------------------------------------------------------------------------
module integer_square_root_top import isqrt_pkg::*; #(
  parameter int unsigned OPERAND_BITS = 32,
  localparam int unsigned ROOT_BITS   = (OPERAND_BITS + 1) / 2
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  output logic                    stall_o,
  input  logic [OPERAND_BITS-1:0] radicand_i,
  output logic                    valid_o,
  input  logic                    stall_i,
  output logic [ROOT_BITS-1:0]    root_o
);

  localparam int unsigned NUM_STAGES = (ROOT_BITS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
  localparam int unsigned PAD_BITS   = 2 * STEPS_PER_STAGE * NUM_STAGES;
  localparam int unsigned REM_BITS   = ROOT_BITS + 2;

  logic                 valid [NUM_STAGES+1];
  logic                 ready [NUM_STAGES+1];
  logic [REM_BITS-1:0]  rem   [NUM_STAGES+1];
  logic [ROOT_BITS-1:0] root  [NUM_STAGES+1];
  logic [PAD_BITS-1:0]  opnd  [NUM_STAGES+1];

  assign valid[0] = valid_i;
  assign rem[0]   = '0;
  assign root[0]  = '0;
  assign opnd[0]  = PAD_BITS'(radicand_i);

  for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
    isqrt_stage #(
      .ROOT_BITS (ROOT_BITS),
      .PAD_BITS  (PAD_BITS)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid[g]),
      .ready_o (ready[g]),
      .rem_i   (rem[g]),
      .root_i  (root[g]),
      .opnd_i  (opnd[g]),
      .valid_o (valid[g+1]),
      .ready_i (ready[g+1]),
      .rem_o   (rem[g+1]),
      .root_o  (root[g+1]),
      .opnd_o  (opnd[g+1])
    );
  end

  assign ready[NUM_STAGES] = !stall_i;
  assign stall_o           = !ready[0];
  assign valid_o           = valid[NUM_STAGES];
  assign root_o            = root[NUM_STAGES];

endmodule

### design/isqrt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isqrt_checker
// Port-level checks on the square root pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module isqrt_checker #(
  parameter int unsigned ROOT_BITS = 16
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 stall_o,
  input logic                 valid_o,
  input logic                 stall_i,
  input logic [ROOT_BITS-1:0] root_o
);

  // a result held back by the receiver stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o)
    else $error("result dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> $stable(root_o))
    else $error("root changed while stalled");

  // back-pressure only reaches the input once the output itself is stuck
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> valid_o && stall_i)
    else $error("input stalled without a stalled result");

  // nothing leaves the pipeline straight out of reset
  assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !valid_o)
    else $error("result offered straight after reset");

endmodule

bind integer_square_root_top isqrt_checker #(
  .ROOT_BITS ((OPERAND_BITS + 1) / 2)
) u_isqrt_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .stall_o (stall_o),
  .valid_o (valid_o),
  .stall_i (stall_i),
  .root_o  (root_o)
);
